// ----- rtl/qph_pkg.sv -----
// ----------------------------------------------------------------------------
// qph_pkg
// Shared types and constants of the quadratic probe hash table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qph_pkg;

	localparam int KEY_W      = 32;
	localparam int CFG_W      = 11;
	localparam int IDX_W      = 10;
	localparam int ST_W       = 2;
	localparam int MOD_DIGITS = 4;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1021;
	localparam logic [CFG_W-1:0] TABLE_SIZE_MIN   = 11'd2;
	localparam logic [CFG_W-1:0] PROBE_INC_FIRST  = 11'd1;
	localparam logic [CFG_W-1:0] PROBE_INC_STEP   = 11'd2;

	localparam logic CFG_IDX_TABLE_SIZE = 1'b0;

	typedef enum logic [1:0] {
		MODE_FIND,
		MODE_INSERT,
		MODE_DELETE,
		MODE_RETRIEVE
	} mode_t;

	typedef enum logic [ST_W-1:0] {
		ST_EMPTY,
		ST_LIVE,
		ST_DELETED
	} slot_st_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_READ,
		S_CHECK,
		S_RESP
	} fsm_t;

	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] dividend;
		logic [CFG_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [CFG_W-1:0] remainder;
	} mod_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/quadratic_probe_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit
// Open-addressing hash table of 32-bit keys with quadratic probing.
// ----------------------------------------------------------------------------
// Each item runs find, insert, delete or retrieve and returns one result item.
// Items are handled one at a time. Find, insert and delete first reduce the
// key modulo the active, clamped table size in a 4-bit-per-cycle divider,
// then examine one slot per cycle through the registered read port of the
// status and key memories, probing at most as many slots as the active
// table size. After reset the status memory is swept to empty over all
// MAX_SLOTS slots, one slot per cycle; no item is taken during that sweep,
// while register writes are accepted as usual.
`default_nettype none

module quadratic_probe_hash_table_unit import qph_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         mode,
	input  wire logic [KEY_W-1:0]   key,
	input  wire logic [IDX_W-1:0]   slot_index,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [IDX_W-1:0]   position,
	output logic      [ST_W-1:0]    slot_state,
	output logic      [KEY_W-1:0]   stored_key,
	output logic                    hit,
	output logic                    probe_exhausted
);

	localparam int          AW    = $clog2(MAX_SLOTS);
	localparam logic [31:0] MAX_U = 32'(MAX_SLOTS);

	fsm_t             state_q, state_d;
	logic [AW-1:0]    clr_q;
	logic             clr_last;

	logic [CFG_W-1:0] table_size;
	logic [CFG_W-1:0] n_act;
	mod_req_t         mod_req;
	mod_rsp_t         mod_rsp;

	mode_t            mode_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] idx_q;
	logic [CFG_W-1:0] n_q;
	logic [CFG_W-1:0] pos_q;
	logic [CFG_W-1:0] inc_q;
	logic [CFG_W-1:0] tries_q;
	logic [CFG_W-1:0] pos_nxt;
	logic [CFG_W-1:0] inc_nxt;
	logic [CFG_W:0]   pos_sum;
	logic [CFG_W:0]   inc_sum;

	logic             st_we;
	logic [AW-1:0]    st_waddr;
	logic [ST_W-1:0]  st_wdata;
	logic [ST_W-1:0]  st_rdata;
	logic             key_we;
	logic [KEY_W-1:0] key_rdata;
	logic [AW-1:0]    raddr;

	slot_st_t         st_rd;
	slot_st_t         st_new;
	logic             is_retr;
	logic             stop;
	logic             last_try;
	logic             idx_oor;
	logic             ins_wr;
	logic             out_free;

	logic [IDX_W-1:0] res_pos_q;
	logic [ST_W-1:0]  res_st_q;
	logic [KEY_W-1:0] res_key_q;
	logic             res_hit_q;
	logic             res_exh_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] out_pos_q;
	logic [ST_W-1:0]  out_st_q;
	logic [KEY_W-1:0] out_key_q;
	logic             out_hit_q;
	logic             out_exh_q;

	qph_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.table_size (table_size)
	);

	qph_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	qph_ram #(.WIDTH(ST_W), .DEPTH(MAX_SLOTS)) u_status_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (raddr),
		.rdata (st_rdata)
	);

	qph_ram #(.WIDTH(KEY_W), .DEPTH(MAX_SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (AW'(pos_q)),
		.wdata (key_q),
		.raddr (raddr),
		.rdata (key_rdata)
	);

	// active table size, clamped
	always_comb begin
		if (table_size < TABLE_SIZE_MIN) begin
			n_act = TABLE_SIZE_MIN;
		end else if (32'(table_size) > MAX_U) begin
			n_act = CFG_W'(MAX_SLOTS);
		end else begin
			n_act = table_size;
		end
	end

	assign clr_last = (clr_q == AW'(MAX_SLOTS - 1));

	// probe step, increments kept reduced modulo n
	assign pos_sum = {1'b0, pos_q} + {1'b0, inc_q};
	assign inc_sum = {1'b0, inc_q} + {1'b0, PROBE_INC_STEP};
	assign pos_nxt = (pos_sum >= {1'b0, n_q}) ? CFG_W'(pos_sum - {1'b0, n_q})
	                                          : pos_sum[CFG_W-1:0];
	assign inc_nxt = (inc_sum >= {1'b0, n_q}) ? CFG_W'(inc_sum - {1'b0, n_q})
	                                          : inc_sum[CFG_W-1:0];

	assign st_rd    = slot_st_t'(st_rdata);
	assign is_retr  = (mode_q == MODE_RETRIEVE);
	assign stop     = (st_rd == ST_EMPTY) || (key_rdata == key_q);
	assign last_try = (tries_q == n_q);
	assign idx_oor  = (32'(idx_q) >= MAX_U);
	assign ins_wr   = (mode_q == MODE_INSERT) && (st_rd != ST_LIVE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		st_new = st_rd;
		case (mode_q)
			MODE_INSERT: begin
				st_new = ST_LIVE;
			end
			MODE_DELETE: begin
				if (st_rd == ST_LIVE) begin
					st_new = ST_DELETED;
				end
			end
			default: begin
				st_new = st_rd;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = (mode_t'(mode) == MODE_RETRIEVE) ? S_READ : S_DIV;
				end
			end
			S_DIV: begin
				if (mod_rsp.done) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (is_retr || stop || last_try) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		in_ready         = 1'b0;
		mod_req.start    = 1'b0;
		mod_req.dividend = key;
		mod_req.divisor  = n_act;
		st_we            = 1'b0;
		st_waddr         = AW'(pos_q);
		st_wdata         = st_new;
		key_we           = 1'b0;
		raddr            = is_retr ? AW'(idx_q) : AW'(pos_q);
		case (state_q)
			S_CLEAR: begin
				st_we    = 1'b1;
				st_waddr = clr_q;
				st_wdata = ST_EMPTY;
			end
			S_IDLE: begin
				in_ready      = 1'b1;
				mod_req.start = in_valid && (mode_t'(mode) != MODE_RETRIEVE);
			end
			S_CHECK: begin
				raddr = AW'(pos_nxt);
				if (!is_retr && stop) begin
					st_we  = (st_new != st_rd);
					key_we = ins_wr;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= mode_t'(mode);
				key_q  <= key;
				idx_q  <= slot_index;
				n_q    <= n_act;
			end
			S_DIV: begin
				pos_q   <= mod_rsp.remainder;
				inc_q   <= PROBE_INC_FIRST;
				tries_q <= PROBE_INC_FIRST;
			end
			S_CHECK: begin
				res_hit_q <= 1'b0;
				res_exh_q <= 1'b0;
				if (is_retr) begin
					res_pos_q <= idx_q;
					if (idx_oor || st_rd == ST_EMPTY) begin
						res_st_q  <= ST_EMPTY;
						res_key_q <= '0;
					end else begin
						res_st_q  <= st_rd;
						res_key_q <= key_rdata;
					end
				end else if (stop) begin
					res_pos_q <= IDX_W'(pos_q);
					res_st_q  <= st_new;
					res_hit_q <= (st_rd == ST_LIVE) && (key_rdata == key_q);
					if (st_new == ST_EMPTY) begin
						res_key_q <= '0;
					end else begin
						res_key_q <= ins_wr ? key_q : key_rdata;
					end
				end else if (last_try) begin
					res_pos_q <= '0;
					res_st_q  <= ST_EMPTY;
					res_key_q <= '0;
					res_exh_q <= 1'b1;
				end else begin
					pos_q   <= pos_nxt;
					inc_q   <= inc_nxt;
					tries_q <= tries_q + 1'b1;
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_pos_q <= res_pos_q;
					out_st_q  <= res_st_q;
					out_key_q <= res_key_q;
					out_hit_q <= res_hit_q;
					out_exh_q <= res_exh_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign position        = out_pos_q;
	assign slot_state      = out_st_q;
	assign stored_key      = out_key_q;
	assign hit             = out_hit_q;
	assign probe_exhausted = out_exh_q;

`ifndef SYNTHESIS
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("item taken during status sweep");

	a_pos_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && !is_retr) |-> (pos_q < n_q))
		else $error("probe position outside table");

	a_exhausted_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && probe_exhausted) |->
		(position == '0 && !hit && slot_state == ST_EMPTY && stored_key == '0))
		else $error("exhausted result carries slot data");

	a_hit_live: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (!probe_exhausted && slot_state != ST_EMPTY))
		else $error("hit on empty or exhausted result");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && out_free) |=> (out_valid && state_q == S_IDLE))
		else $error("result not presented after response");
`endif

endmodule

`default_nettype wire

// ----- rtl/qph_ram.sv -----
// ----------------------------------------------------------------------------
// qph_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/qph_mod.sv -----
// ----------------------------------------------------------------------------
// qph_mod
// Iterative key modulo table size, restoring, several bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qph_mod import qph_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mod_req_t req,
	output mod_rsp_t      rsp
);

	localparam int STEPS = KEY_W / MOD_DIGITS;
	localparam int CW    = $clog2(STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [KEY_W-1:0] dvd_q;
	logic [CFG_W-1:0] dvs_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] rem_nxt;

	always_comb begin
		logic [CFG_W:0]   t;
		logic [CFG_W-1:0] r;
		r = rem_q;
		t = '0;
		for (int i = 0; i < MOD_DIGITS; i++) begin
			t = {r, dvd_q[KEY_W-1-i]};
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
			end
			r = t[CFG_W-1:0];
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << MOD_DIGITS;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// ----- rtl/qph_cfg.sv -----
// ----------------------------------------------------------------------------
// qph_cfg
// APB register file holding the table size.
// ----------------------------------------------------------------------------
`default_nettype none

module qph_cfg import qph_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output logic      [CFG_W-1:0]   table_size
);

	logic [CFG_W-1:0] table_size_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RESET;
		end else if (wr_en && paddr[2] == CFG_IDX_TABLE_SIZE) begin
			table_size_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == CFG_IDX_TABLE_SIZE) begin
			prdata = PDATA_W'(table_size_q);
		end
	end

	assign table_size = table_size_q;

endmodule

`default_nettype wire

// ----- tb/tb_quadratic_probe_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// tb_quadratic_probe_hash_table_unit
// Self-checking bench for the quadratic probe hash table unit.
// ----------------------------------------------------------------------------
// A shadow copy of the slot status and key stores predicts every result item.
// Directed items cover collisions, deleted slots, exhausted probes, shrunk
// tables and out-of-range sizes. Random phases sweep many table sizes, mostly
// with colliding key pools; the first eight stall both handshakes at random.
// ----------------------------------------------------------------------------

module tb_quadratic_probe_hash_table_unit import qph_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_COUNT = 1024;
	localparam int LIMIT_CYCLES = 5_000_000;
	localparam int SETTLE_CYCLES = 1100;
	localparam int PHASE_ITEMS = 34;
	localparam logic [PADDR_W-1:0] TABLE_SIZE_ADDR = PADDR_W'(4 * CFG_IDX_TABLE_SIZE);

	typedef struct {
		logic [IDX_W-1:0] position;
		slot_st_t         state;
		logic [KEY_W-1:0] stored;
		logic             hit;
		logic             exhausted;
	} table_result_t;

	class hash_table_shadow;
		slot_st_t         status_mem[SLOT_COUNT];
		logic [KEY_W-1:0] key_mem[SLOT_COUNT];
		int unsigned      size_reg;
		table_result_t    pending[$];
		int unsigned      fail_count;
		int unsigned      checked;
		int unsigned      hits;
		int unsigned      exhausted;
		int unsigned      mode_count[4];

		function new();
			size_reg = TABLE_SIZE_RESET;
			foreach (status_mem[i]) begin
				status_mem[i] = ST_EMPTY;
				key_mem[i] = '0;
			end
		endfunction

		function int unsigned active_size();
			if (size_reg < 2)
				return 2;
			if (size_reg > SLOT_COUNT)
				return SLOT_COUNT;
			return size_reg;
		endfunction

		function void note_request(mode_t m, logic [KEY_W-1:0] k, logic [IDX_W-1:0] idx);
			table_result_t r;
			int unsigned n;
			int unsigned pos;
			int unsigned tries;
			bit found;
			r.position = '0;
			r.state = ST_EMPTY;
			r.stored = '0;
			r.hit = 1'b0;
			r.exhausted = 1'b0;
			found = 1'b0;
			mode_count[m]++;
			if (m == MODE_RETRIEVE) begin
				r.position = idx;
				r.state = status_mem[idx];
				r.stored = (status_mem[idx] == ST_EMPTY) ? '0 : key_mem[idx];
			end else begin
				n = active_size();
				pos = k % n;
				for (tries = 1; tries <= n; tries++) begin
					if (status_mem[pos] == ST_EMPTY || key_mem[pos] == k) begin
						found = 1'b1;
						break;
					end
					pos = (pos + 2 * tries - 1) % n;
				end
				if (!found) begin
					r.exhausted = 1'b1;
				end else begin
					r.hit = (status_mem[pos] == ST_LIVE && key_mem[pos] == k);
					if (m == MODE_INSERT && status_mem[pos] != ST_LIVE) begin
						status_mem[pos] = ST_LIVE;
						key_mem[pos] = k;
					end else if (m == MODE_DELETE && status_mem[pos] == ST_LIVE) begin
						status_mem[pos] = ST_DELETED;
					end
					r.position = pos[IDX_W-1:0];
					r.state = status_mem[pos];
					r.stored = (status_mem[pos] == ST_EMPTY) ? '0 : key_mem[pos];
				end
			end
			pending.push_back(r);
		endfunction

		function void report(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				fail_count++;
			end
		endfunction

		function void check_response(logic [IDX_W-1:0] p, logic [ST_W-1:0] st,
				logic [KEY_W-1:0] sk, logic h, logic ex);
			table_result_t r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result item, position %0h", $time, p);
				fail_count++;
				return;
			end
			r = pending.pop_front();
			checked++;
			hits += r.hit;
			exhausted += r.exhausted;
			report("position", KEY_W'(r.position), KEY_W'(p));
			report("slot_state", KEY_W'(r.state), KEY_W'(st));
			report("stored_key", r.stored, sk);
			report("hit", KEY_W'(r.hit), KEY_W'(h));
			report("probe_exhausted", KEY_W'(r.exhausted), KEY_W'(ex));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	mode_t              mode = MODE_FIND;
	logic [KEY_W-1:0]   key = '0;
	logic [IDX_W-1:0]   slot_index = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [IDX_W-1:0]   position;
	logic [ST_W-1:0]    slot_state;
	logic [KEY_W-1:0]   stored_key;
	logic               hit;
	logic               probe_exhausted;

	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned cycle_count = 0;
	hash_table_shadow shadow = new();

	quadratic_probe_hash_table_unit #(
		.MAX_SLOTS(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.key(key),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position(position),
		.slot_state(slot_state),
		.stored_key(stored_key),
		.hit(hit),
		.probe_exhausted(probe_exhausted)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			shadow.check_response(position, slot_state, stored_key, hit, probe_exhausted);
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_op(mode_t m, logic [KEY_W-1:0] k, logic [IDX_W-1:0] idx);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		key <= k;
		slot_index <= idx;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		shadow.note_request(m, k, idx);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (shadow.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_table_size(int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TABLE_SIZE_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		shadow.size_reg = value & 32'h7FF;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_phase(int unsigned size_value, int unsigned count);
		logic [KEY_W-1:0] pool[12];
		logic [KEY_W-1:0] base;
		logic [KEY_W-1:0] k;
		logic [IDX_W-1:0] idx;
		int unsigned n;
		int unsigned pick;
		mode_t m;
		write_table_size(size_value);
		n = shadow.active_size();
		base = $urandom();
		foreach (pool[i])
			pool[i] = (i % 2) ? base + i * n : $urandom();
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				m = MODE_INSERT;
			else if (pick < 60)
				m = MODE_FIND;
			else if (pick < 80)
				m = MODE_DELETE;
			else
				m = MODE_RETRIEVE;
			k = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 11)] : $urandom();
			if ($urandom_range(0, 1))
				idx = IDX_W'($urandom_range(0, n - 1));
			else
				idx = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
			send_op(m, k, idx);
			if (i == count / 2)
				settle();
		end
		settle();
	endtask

	initial begin
		int unsigned sizes[12];
		sizes = '{3, 5, 7, 16, 1, 64, 1024, 13, 2, 128, 1500, 31};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size, collisions and deleted slots
		send_op(MODE_FIND, 32'd0, '0);
		send_op(MODE_INSERT, 32'd0, '0);
		send_op(MODE_INSERT, 32'd0, '0);
		send_op(MODE_INSERT, 32'd1021, '0);
		send_op(MODE_INSERT, 32'hFFFF_FFFF, '0);
		send_op(MODE_FIND, 32'hFFFF_FFFF, '0);
		send_op(MODE_DELETE, 32'd1021, '0);
		send_op(MODE_FIND, 32'd1021, '0);
		send_op(MODE_INSERT, 32'd1021, '0);
		send_op(MODE_DELETE, 32'd0, '0);
		send_op(MODE_DELETE, 32'd0, '0);
		send_op(MODE_INSERT, 32'd2042, '0);
		send_op(MODE_DELETE, 32'd3063, 10'h3FF);
		send_op(MODE_RETRIEVE, 32'hFFFF_FFFF, 10'd0);
		send_op(MODE_RETRIEVE, 32'd0, 10'd4);
		send_op(MODE_RETRIEVE, 32'd0, 10'h3FF);
		send_op(MODE_RETRIEVE, 32'd0, 10'h200);
		settle();

		// shrunk table, full probes and clamped sizes
		write_table_size(2);
		send_op(MODE_FIND, 32'd0, '0);
		send_op(MODE_INSERT, 32'd0, '0);
		send_op(MODE_INSERT, 32'd7, '0);
		send_op(MODE_DELETE, 32'd1021, '0);
		settle();
		write_table_size(0);
		send_op(MODE_INSERT, 32'd9, '0);
		settle();
		write_table_size(1);
		send_op(MODE_FIND, 32'd1021, '0);
		settle();
		write_table_size(2047);
		send_op(MODE_INSERT, 32'hFFFF_FFFF, '0);
		send_op(MODE_RETRIEVE, 32'd0, 10'h3FF);
		send_op(MODE_RETRIEVE, 32'd0, 10'd4);
		settle();
		write_table_size(1024);
		send_op(MODE_FIND, 32'hFFFF_FFFF, '0);
		settle();

		foreach (sizes[p]) begin
			case (p / 4)
				0: begin
					send_idle = 11;
					recv_idle = 83;
				end
				1: begin
					send_idle = 83;
					recv_idle = 11;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			random_phase(sizes[p], PHASE_ITEMS);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("checked %0d results: %0d find, %0d insert, %0d delete, %0d retrieve",
			shadow.checked, shadow.mode_count[MODE_FIND], shadow.mode_count[MODE_INSERT],
			shadow.mode_count[MODE_DELETE], shadow.mode_count[MODE_RETRIEVE]);
		$display("table sizes 0 to 2047 used, %0d hits, %0d exhausted probes",
			shadow.hits, shadow.exhausted);
		if (shadow.fail_count == 0 && shadow.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
